@@ hw/rtl/clsf_pkg.sv @@
// Shared types, constants and helper functions of the caseless line filter.
package clsf_pkg;

   localparam int PATTERN_MAX     = 32;
   localparam int LEN_WIDTH       = 6;
   localparam int BYTE_WIDTH      = 8;
   localparam int WORD_WIDTH      = 64;
   localparam int WORD_COUNT      = 4;
   localparam int CHAR_COUNT      = WORD_COUNT * (WORD_WIDTH / BYTE_WIDTH);
   localparam int CHAR_IDX_WIDTH  = $clog2(CHAR_COUNT);
   localparam int DATA_WIDTH      = 32;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QPTR_WIDTH      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [BYTE_WIDTH-1:0] NEWLINE_BYTE = 8'd10;
   localparam logic [BYTE_WIDTH-1:0] CR_BYTE      = 8'd13;
   localparam logic [BYTE_WIDTH-1:0] ZERO_BYTE    = 8'd0;
   localparam logic [BYTE_WIDTH-1:0] UPPER_A      = 8'h41;
   localparam logic [BYTE_WIDTH-1:0] UPPER_Z      = 8'h5A;
   localparam logic [BYTE_WIDTH-1:0] CASE_OFFSET  = 8'd32;
   localparam logic [LEN_WIDTH-1:0]  LINE_CNT_MAX = '1;
   localparam logic [DATA_WIDTH-1:0] DATA_MAX     = '1;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PATTERN_LENGTH = 3'd0,
      CSR_PATTERN_WORD_0 = 3'd1,
      CSR_PATTERN_WORD_1 = 3'd2,
      CSR_PATTERN_WORD_2 = 3'd3,
      CSR_PATTERN_WORD_3 = 3'd4
   } csr_reg_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] line_start;
      logic [DATA_WIDTH-1:0] newline_pos;
   } line_rec_type;

   function automatic logic [BYTE_WIDTH-1:0] fold_byte(input logic [BYTE_WIDTH-1:0] c);
      logic [BYTE_WIDTH-1:0] r;
      r = c;
      if (c inside {[UPPER_A:UPPER_Z]}) begin
         r = c + CASE_OFFSET;
      end
      return r;
   endfunction

   function automatic logic [DATA_WIDTH-1:0] sat_inc(input logic [DATA_WIDTH-1:0] v);
      logic [DATA_WIDTH-1:0] r;
      r = (v == DATA_MAX) ? v : v + DATA_WIDTH'(1);
      return r;
   endfunction

endpackage

@@ hw/rtl/clsf_front.sv @@
// Front part: configuration, byte window, pattern compare and line classification.
module clsf_front import clsf_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [BYTE_WIDTH-1:0]      req_text_byte,
   input  logic                       csr_valid,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [WORD_WIDTH-1:0]      csr_data,
   input  logic                       q_full,
   output logic                       push_valid,
   output line_rec_type               push_rec
);

   logic [LEN_WIDTH-1:0]  pattern_length_ff, pattern_length_in;
   logic [WORD_WIDTH-1:0] pattern_word_ff [WORD_COUNT];
   logic [WORD_WIDTH-1:0] pattern_word_in [WORD_COUNT];
   logic                  hold_ff, hold_in;

   logic [BYTE_WIDTH-1:0] aligned_ff [PATTERN_MAX];
   logic [BYTE_WIDTH-1:0] aligned_in [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] mask_ff, mask_in;
   logic [PATTERN_MAX-1:0] last_ff, last_in;
   logic [LEN_WIDTH-1:0]   len_ff, len_in;

   logic [BYTE_WIDTH-1:0] recent_ff [PATTERN_MAX];
   logic [BYTE_WIDTH-1:0] recent_in [PATTERN_MAX];
   logic [LEN_WIDTH-1:0]  bsls_ff, bsls_in;
   logic                  line_match_ff, line_match_in;
   logic [DATA_WIDTH-1:0] offset_ff, offset_in;
   logic [DATA_WIDTH-1:0] line_start_ff, line_start_in;

   logic [BYTE_WIDTH-1:0] pat_chars [CHAR_COUNT];
   logic [LEN_WIDTH-1:0]  len_eff;
   logic [LEN_WIDTH-1:0]  char_k;
   logic [BYTE_WIDTH-1:0] new_win [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] eq_vec, cr_vec;
   logic                  accept, is_newline, byte_hit;

   // configuration registers
   always_comb begin
      pattern_length_in = pattern_length_ff;
      pattern_word_in   = pattern_word_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PATTERN_LENGTH: pattern_length_in  = csr_data[LEN_WIDTH-1:0];
            CSR_PATTERN_WORD_0: pattern_word_in[0] = csr_data;
            CSR_PATTERN_WORD_1: pattern_word_in[1] = csr_data;
            CSR_PATTERN_WORD_2: pattern_word_in[2] = csr_data;
            CSR_PATTERN_WORD_3: pattern_word_in[3] = csr_data;
            default: ;
         endcase
      end
   end

   assign hold_in = csr_valid;

   // aligned pattern: position j of the window meets pattern char len-1-j
   always_comb begin
      for (int c = 0; c < CHAR_COUNT; c++) begin
         pat_chars[c] = pattern_word_ff[c / (WORD_WIDTH / BYTE_WIDTH)]
                        [(c % (WORD_WIDTH / BYTE_WIDTH)) * BYTE_WIDTH +: BYTE_WIDTH];
      end
      len_eff = (pattern_length_ff > LEN_WIDTH'(PATTERN_MAX)) ?
                LEN_WIDTH'(PATTERN_MAX) : pattern_length_ff;
      len_in  = len_eff;
      char_k  = '0;
      for (int j = 0; j < PATTERN_MAX; j++) begin
         mask_in[j]    = LEN_WIDTH'(j) < len_eff;
         last_in[j]    = (LEN_WIDTH'(j) + LEN_WIDTH'(1)) == len_eff;
         char_k        = len_eff - LEN_WIDTH'(j) - LEN_WIDTH'(1);
         aligned_in[j] = ZERO_BYTE;
         if (mask_in[j] && (char_k < LEN_WIDTH'(CHAR_COUNT))) begin
            aligned_in[j] = fold_byte(pat_chars[char_k[CHAR_IDX_WIDTH-1:0]]);
         end
      end
   end

   assign req_ready  = !q_full && !hold_ff;
   assign accept     = req_valid && req_ready;
   assign is_newline = (req_text_byte == NEWLINE_BYTE);

   always_comb begin
      new_win[0] = fold_byte(req_text_byte);
      for (int i = 1; i < PATTERN_MAX; i++) begin
         new_win[i] = recent_ff[i-1];
      end
      for (int i = 0; i < PATTERN_MAX; i++) begin
         eq_vec[i] = (new_win[i] == aligned_ff[i]) || !mask_ff[i];
         cr_vec[i] = (new_win[i] == CR_BYTE) && last_ff[i];
      end
   end

   always_comb begin
      recent_in     = recent_ff;
      bsls_in       = bsls_ff;
      line_match_in = line_match_ff;
      offset_in     = offset_ff;
      line_start_in = line_start_ff;
      byte_hit      = 1'b0;
      push_valid    = 1'b0;
      push_rec.line_start  = line_start_ff;
      push_rec.newline_pos = offset_ff;
      if (accept) begin
         offset_in = sat_inc(offset_ff);
         if (is_newline) begin
            push_valid    = line_match_ff;
            bsls_in       = '0;
            line_match_in = 1'b0;
            line_start_in = sat_inc(offset_ff);
         end else begin
            recent_in = new_win;
            if (bsls_ff != LINE_CNT_MAX) begin
               bsls_in = bsls_ff + LEN_WIDTH'(1);
            end
            if (len_ff == '0) begin
               byte_hit = (req_text_byte == ZERO_BYTE);
            end else begin
               byte_hit = (bsls_in >= len_ff) && (&eq_vec) && !(|cr_vec);
            end
            line_match_in = line_match_ff || byte_hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= '0;
         pattern_word_ff   <= '{default: '0};
         hold_ff           <= 1'b1;
         recent_ff         <= '{default: '0};
         bsls_ff           <= '0;
         line_match_ff     <= 1'b0;
         offset_ff         <= '0;
         line_start_ff     <= '0;
      end else begin
         pattern_length_ff <= pattern_length_in;
         pattern_word_ff   <= pattern_word_in;
         hold_ff           <= hold_in;
         recent_ff         <= recent_in;
         bsls_ff           <= bsls_in;
         line_match_ff     <= line_match_in;
         offset_ff         <= offset_in;
         line_start_ff     <= line_start_in;
      end
   end

   always_ff @(posedge clock) begin
      aligned_ff <= aligned_in;
      mask_ff    <= mask_in;
      last_ff    <= last_in;
      len_ff     <= len_in;
   end

endmodule

@@ hw/rtl/clsf_queue.sv @@
// Two-entry queue of matching line records between front and back.
module clsf_queue import clsf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   input  line_rec_type push_rec,
   output logic         q_full,
   output logic         q_valid,
   output line_rec_type q_rec,
   input  logic         pop
);

   line_rec_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign q_full  = (count_ff == QCNT_WIDTH'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_rec   = entry_ff[rd_ptr_ff];
   assign do_push = push_valid && !q_full;
   assign do_pop  = pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                     : wr_ptr_ff + QPTR_WIDTH'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                     : rd_ptr_ff + QPTR_WIDTH'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + QCNT_WIDTH'(1);
         2'b01:   count_in = count_ff - QCNT_WIDTH'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

@@ hw/rtl/clsf_back.sv @@
// Back part: match counting, line length and the result output register.
module clsf_back import clsf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  line_rec_type          q_rec,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DATA_WIDTH-1:0] rsp_line_offset,
   output logic [DATA_WIDTH-1:0] rsp_line_length,
   output logic [DATA_WIDTH-1:0] rsp_match_count
);

   logic                  valid_ff, valid_in;
   logic [DATA_WIDTH-1:0] matched_ff, matched_in;
   logic [DATA_WIDTH-1:0] offset_ff, offset_in;
   logic [DATA_WIDTH-1:0] length_ff, length_in;

   assign pop = q_valid && (!valid_ff || rsp_ready);

   always_comb begin
      valid_in   = valid_ff && !rsp_ready;
      matched_in = matched_ff;
      offset_in  = offset_ff;
      length_in  = length_ff;
      if (pop) begin
         valid_in   = 1'b1;
         matched_in = sat_inc(matched_ff);
         offset_in  = q_rec.line_start;
         length_in  = q_rec.newline_pos - q_rec.line_start;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         matched_ff <= '0;
      end else begin
         valid_ff   <= valid_in;
         matched_ff <= matched_in;
      end
   end

   always_ff @(posedge clock) begin
      offset_ff <= offset_in;
      length_ff <= length_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_line_offset = offset_ff;
   assign rsp_line_length = length_ff;
   assign rsp_match_count = matched_ff;

endmodule

@@ hw/rtl/caseless_line_substring_filter_unit.sv @@
// Top level of the caseless line substring filter.
//
// The req channel takes one text byte per word; a newline byte ends a line.
// The csr channel writes the pattern length (index 0) and four pattern words
// (indexes 1 to 4); csr_ready is always high. Pattern and text bytes compare
// with A-Z folded to lower case.
// The rsp channel gives one word per newline that ends a line holding the
// pattern: line start offset, line length and running match count.
// Throughput: one byte per cycle while req_ready is high, set by the
// combinational window compare over all pattern positions in the front part.
// A result goes through the line queue, then the output register, to rsp.
// A csr write holds req_ready low for the following cycle while the aligned
// pattern register reloads.
// Reset clears the pattern, the byte window, the front offsets and the match count;
// req_ready is held low by the hold register, which reset sets.
// When the receiver stalls, the output register and the two-entry queue fill;
// then req_ready drops and the front holds.
module caseless_line_substring_filter_unit import clsf_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [BYTE_WIDTH-1:0]      req_text_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [DATA_WIDTH-1:0]      rsp_line_offset,
   output logic [DATA_WIDTH-1:0]      rsp_line_length,
   output logic [DATA_WIDTH-1:0]      rsp_match_count,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [WORD_WIDTH-1:0]      csr_data
);

   logic         q_full;
   logic         push_valid;
   line_rec_type push_rec;
   logic         q_valid;
   line_rec_type q_rec;
   logic         pop;

   assign csr_ready = 1'b1;

   clsf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_text_byte (req_text_byte),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .q_full        (q_full),
      .push_valid    (push_valid),
      .push_rec      (push_rec)
   );

   clsf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_rec   (push_rec),
      .q_full     (q_full),
      .q_valid    (q_valid),
      .q_rec      (q_rec),
      .pop        (pop)
   );

   clsf_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_rec           (q_rec),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_line_offset (rsp_line_offset),
      .rsp_line_length (rsp_line_length),
      .rsp_match_count (rsp_match_count)
   );

endmodule

@@ hw/rtl/clsf_checker.sv @@
// Port-level checker of the caseless line filter and its bind.
module clsf_checker import clsf_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [DATA_WIDTH-1:0] rsp_match_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_match_count))
      else $error("rsp word dropped or changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_match_count != '0)
      else $error("match count zero on a result");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(rsp_valid && rsp_ready) && rsp_valid |->
         (rsp_match_count == $past(rsp_match_count) + DATA_WIDTH'(1)) ||
         (rsp_match_count == DATA_MAX && $past(rsp_match_count) == DATA_MAX))
      else $error("match count did not advance by one");

endmodule

bind caseless_line_substring_filter_unit clsf_checker u_clsf_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_match_count (rsp_match_count)
);

@@ test/caseless_line_substring_filter_unit_test.sv @@
// Self-checking testbench of the caseless line substring filter: directed and random text.
`timescale 1ns / 1ps

module caseless_line_substring_filter_unit_test;
   import clsf_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned IDLE_PERCENT  = 32;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned RANDOM_END    = 1250;
   localparam int unsigned PHASE_BYTES   = 200;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FIRST_UNUSED =
      CSR_INDEX_WIDTH'(CSR_PATTERN_WORD_3 + 1);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LAST_INDEX   = '1;
   localparam logic [BYTE_WIDTH-1:0]      LOWER_A          = UPPER_A + CASE_OFFSET;
   localparam logic [BYTE_WIDTH-1:0]      LOWER_Z          = UPPER_Z + CASE_OFFSET;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] line_offset;
      logic [DATA_WIDTH-1:0] line_length;
      logic [DATA_WIDTH-1:0] match_count;
   } line_report_type;

   logic                       clock         = 1'b0;
   logic                       reset         = 1'b1;
   logic                       req_valid     = 1'b0;
   logic                       req_ready;
   logic [BYTE_WIDTH-1:0]      req_text_byte = '0;
   logic                       rsp_valid;
   logic                       rsp_ready     = 1'b0;
   logic [DATA_WIDTH-1:0]      rsp_line_offset;
   logic [DATA_WIDTH-1:0]      rsp_line_length;
   logic [DATA_WIDTH-1:0]      rsp_match_count;
   logic                       csr_valid     = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index     = '0;
   logic [WORD_WIDTH-1:0]      csr_data      = '0;

   // predicted block state
   logic [BYTE_WIDTH-1:0] text_window [PATTERN_MAX];
   logic [LEN_WIDTH-1:0]  line_fill   = '0;
   logic                  line_hit    = 1'b0;
   logic [DATA_WIDTH-1:0] next_offset = '0;
   logic [DATA_WIDTH-1:0] line_begin  = '0;
   logic [DATA_WIDTH-1:0] hit_count   = '0;
   logic [LEN_WIDTH-1:0]  pat_len     = '0;
   logic [WORD_WIDTH-1:0] pat_words [WORD_COUNT];

   line_report_type pending_lines [$];

   int unsigned fail_count    = 0;
   int unsigned cycle_count   = 0;
   int unsigned sent_bytes    = 0;
   int unsigned rsp_hold      = 0;
   bit          sender_idling = 1'b1;
   bit          rsp_idling    = 1'b1;

   caseless_line_substring_filter_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_text_byte   (req_text_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_line_offset (rsp_line_offset),
      .rsp_line_length (rsp_line_length),
      .rsp_match_count (rsp_match_count),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("caseless_line_substring_filter_unit_test failed");
         $finish;
      end
   end

   function automatic logic [BYTE_WIDTH-1:0] fold_to_lower(input logic [BYTE_WIDTH-1:0] c);
      if (c >= UPPER_A && c <= UPPER_Z) begin
         return c + CASE_OFFSET;
      end
      return c;
   endfunction

   function automatic logic [DATA_WIDTH-1:0] bump32(input logic [DATA_WIDTH-1:0] v);
      return (v == DATA_MAX) ? v : v + DATA_WIDTH'(1);
   endfunction

   function automatic int unsigned eff_pattern_len();
      return (pat_len > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len);
   endfunction

   function automatic logic [BYTE_WIDTH-1:0] pattern_char_at(input int unsigned k);
      return pat_words[k / 8][(k % 8) * 8 +: 8];
   endfunction

   function automatic bit window_holds_pattern(input int unsigned n);
      int unsigned k;
      if (text_window[n - 1] == CR_BYTE) begin
         return 1'b0;
      end
      for (k = 0; k < n; k++) begin
         if (fold_to_lower(text_window[n - 1 - k]) != fold_to_lower(pattern_char_at(k))) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic void predict_text_byte(input logic [BYTE_WIDTH-1:0] b);
      line_report_type r;
      logic [DATA_WIDTH-1:0] here;
      int unsigned n;
      int i;
      here = next_offset;
      n = eff_pattern_len();
      if (b == NEWLINE_BYTE) begin
         if (line_hit) begin
            hit_count = bump32(hit_count);
            r.line_offset = line_begin;
            r.line_length = here - line_begin;
            r.match_count = hit_count;
            pending_lines.push_back(r);
         end
         line_fill = '0;
         line_hit = 1'b0;
         line_begin = bump32(here);
         next_offset = bump32(here);
         return;
      end
      for (i = PATTERN_MAX - 1; i > 0; i--) begin
         text_window[i] = text_window[i - 1];
      end
      text_window[0] = b;
      if (line_fill != LINE_CNT_MAX) begin
         line_fill++;
      end
      if (n == 0) begin
         if (b == ZERO_BYTE) begin
            line_hit = 1'b1;
         end
      end else if (line_fill >= n && window_holds_pattern(n)) begin
         line_hit = 1'b1;
      end
      next_offset = bump32(here);
   endfunction

   task automatic check_line_report();
      line_report_type want;
      if (pending_lines.size() == 0) begin
         $error("unexpected result: line_offset %0d line_length %0d match_count %0d",
                rsp_line_offset, rsp_line_length, rsp_match_count);
         fail_count++;
         return;
      end
      want = pending_lines.pop_front();
      if (rsp_line_offset !== want.line_offset) begin
         $error("line_offset: expected %0d, actual %0d", want.line_offset, rsp_line_offset);
         fail_count++;
      end
      if (rsp_line_length !== want.line_length) begin
         $error("line_length: expected %0d, actual %0d", want.line_length, rsp_line_length);
         fail_count++;
      end
      if (rsp_match_count !== want.match_count) begin
         $error("match_count: expected %0d, actual %0d", want.match_count, rsp_match_count);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         check_line_report();
      end
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_ready <= !rsp_idling || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   task automatic send_text_byte(input logic [BYTE_WIDTH-1:0] b);
      while (sender_idling && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_text_byte <= b;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      predict_text_byte(b);
      sent_bytes++;
   endtask

   task automatic drain_block();
      req_valid <= 1'b0;
      while (pending_lines.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [WORD_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      case (idx)
         CSR_PATTERN_LENGTH: pat_len = value[LEN_WIDTH-1:0];
         CSR_PATTERN_WORD_0: pat_words[0] = value;
         CSR_PATTERN_WORD_1: pat_words[1] = value;
         CSR_PATTERN_WORD_2: pat_words[2] = value;
         CSR_PATTERN_WORD_3: pat_words[3] = value;
         default: ;
      endcase
   endtask

   task automatic load_pattern(input logic [LEN_WIDTH-1:0] len,
                               input logic [WORD_WIDTH-1:0] w0, w1, w2, w3);
      bit length_first;
      length_first = $urandom_range(1);
      drain_block();
      if (length_first) begin
         write_reg(CSR_PATTERN_LENGTH, WORD_WIDTH'(len));
      end
      write_reg(CSR_PATTERN_WORD_0, w0);
      write_reg(CSR_PATTERN_WORD_1, w1);
      write_reg(CSR_PATTERN_WORD_2, w2);
      write_reg(CSR_PATTERN_WORD_3, w3);
      if (!length_first) begin
         write_reg(CSR_PATTERN_LENGTH, {$urandom, 26'($urandom), len});
      end
      if ($urandom_range(3) == 0) begin
         write_reg(CSR_INDEX_WIDTH'($urandom_range(CSR_FIRST_UNUSED, CSR_LAST_INDEX)),
                   {$urandom, $urandom});
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic [BYTE_WIDTH-1:0] random_case(input logic [BYTE_WIDTH-1:0] c);
      logic [BYTE_WIDTH-1:0] low;
      low = fold_to_lower(c);
      if (low >= LOWER_A && low <= LOWER_Z && $urandom_range(1) == 1) begin
         return low - CASE_OFFSET;
      end
      return low;
   endfunction

   function automatic logic [BYTE_WIDTH-1:0] random_letter();
      return random_case(BYTE_WIDTH'(LOWER_A + $urandom_range(3)));
   endfunction

   function automatic logic [BYTE_WIDTH-1:0] random_pattern_char();
      case ($urandom_range(39))
         0: return CR_BYTE;
         1: return ZERO_BYTE;
         2: return NEWLINE_BYTE;
         3, 4: return BYTE_WIDTH'($urandom_range(255));
         default: return random_letter();
      endcase
   endfunction

   function automatic logic [BYTE_WIDTH-1:0] random_text_char();
      logic [BYTE_WIDTH-1:0] c;
      int unsigned n;
      n = eff_pattern_len();
      case ($urandom_range(9))
         0, 1, 2, 3: begin
            if (n != 0) begin
               c = random_case(pattern_char_at($urandom_range(n - 1)));
            end else begin
               c = ($urandom_range(7) == 0) ? ZERO_BYTE : random_letter();
            end
         end
         4, 5, 6: c = random_letter();
         default: c = BYTE_WIDTH'($urandom_range(255));
      endcase
      if (c == NEWLINE_BYTE) begin
         c = CR_BYTE;
      end
      return c;
   endfunction

   task automatic send_line(input int unsigned body_len, input int unsigned plant_len);
      int unsigned at;
      int unsigned k;
      int unsigned j;
      at = $urandom_range(body_len);
      for (k = 0; k <= body_len; k++) begin
         if (k == at) begin
            for (j = 0; j < plant_len; j++) begin
               send_text_byte(random_case(pattern_char_at(j)));
            end
         end
         if (k < body_len) begin
            send_text_byte(random_text_char());
         end
      end
      send_text_byte(NEWLINE_BYTE);
   endtask

   task automatic send_random_line();
      int unsigned n;
      int unsigned body_len;
      n = eff_pattern_len();
      body_len = ($urandom_range(7) == 0) ? $urandom_range(40, 90) : $urandom_range(12);
      case ($urandom_range(9))
         0: begin
            repeat ($urandom_range(1, 12)) send_text_byte(BYTE_WIDTH'($urandom_range(255)));
         end
         1: send_line($urandom_range(6), (n > 1) ? n - 1 : 0);
         default: send_line(body_len, $urandom_range(1) ? n : 0);
      endcase
   endtask

   task automatic load_random_pattern();
      logic [WORD_WIDTH-1:0] w [WORD_COUNT];
      logic [LEN_WIDTH-1:0] len;
      int unsigned k;
      case ($urandom_range(9))
         0: len = '0;
         1: len = LEN_WIDTH'(1);
         2: len = LEN_WIDTH'(PATTERN_MAX);
         3: len = LEN_WIDTH'($urandom_range(PATTERN_MAX + 1, LINE_CNT_MAX));
         4: len = LEN_WIDTH'($urandom_range(9, PATTERN_MAX - 1));
         default: len = LEN_WIDTH'($urandom_range(2, 6));
      endcase
      for (k = 0; k < CHAR_COUNT; k++) begin
         w[k / 8][(k % 8) * 8 +: 8] = (k < len) ? random_pattern_char()
                                                : BYTE_WIDTH'($urandom_range(255));
      end
      load_pattern(len, w[0], w[1], w[2], w[3]);
   endtask

   task automatic test_default_pattern();
      send_text_byte(ZERO_BYTE);
      send_text_byte(NEWLINE_BYTE);
      send_text_byte(8'hFF);
      send_text_byte(NEWLINE_BYTE);
      send_text_byte(NEWLINE_BYTE);
   endtask

   task automatic test_special_patterns();
      load_pattern(LEN_WIDTH'(2), 64'h5A61, '0, '0, '0);
      send_text_byte(UPPER_A);
      send_text_byte(UPPER_Z);
      send_text_byte(NEWLINE_BYTE);
      load_pattern(LEN_WIDTH'(2), {48'h0, 8'h71, CR_BYTE}, '0, '0, '0);
      send_text_byte(CR_BYTE);
      send_text_byte(8'h51);
      send_text_byte(NEWLINE_BYTE);
      load_pattern(LEN_WIDTH'(2), {48'h0, NEWLINE_BYTE, LOWER_A}, '0, '0, '0);
      send_text_byte(LOWER_A);
      send_text_byte(NEWLINE_BYTE);
      load_pattern(LEN_WIDTH'(2), '0, '1, '1, '1);
      send_text_byte(8'h78);
      send_text_byte(ZERO_BYTE);
      send_text_byte(ZERO_BYTE);
      send_text_byte(NEWLINE_BYTE);
      load_pattern(LINE_CNT_MAX, '1, '1, '1, '1);
      send_text_byte(8'hFF);
      send_text_byte(NEWLINE_BYTE);
      load_pattern(LEN_WIDTH'(1), 64'hFF, '0, '0, '0);
      send_text_byte(8'hFF);
      send_text_byte(NEWLINE_BYTE);
   endtask

   task automatic test_random_lines();
      int unsigned lines;
      while (sent_bytes < RANDOM_END) begin
         load_random_pattern();
         lines = $urandom_range(6, 20);
         repeat (lines) send_random_line();
      end
   endtask

   task automatic test_output_backpressure();
      int unsigned stop_at;
      load_pattern(LEN_WIDTH'(3), {40'h0, random_letter(), random_letter(), random_letter()},
                   '0, '0, '0);
      sender_idling = 1'b0;
      rsp_hold = HOLD_CYCLES;
      stop_at = sent_bytes + PHASE_BYTES;
      while (sent_bytes < stop_at) begin
         send_line($urandom_range(4), $urandom_range(3) != 0 ? eff_pattern_len() : 0);
      end
      sender_idling = 1'b1;
   endtask

   task automatic test_no_idling();
      int unsigned stop_at;
      load_random_pattern();
      sender_idling = 1'b0;
      rsp_idling = 1'b0;
      stop_at = sent_bytes + PHASE_BYTES;
      while (sent_bytes < stop_at) begin
         send_random_line();
      end
      sender_idling = 1'b1;
      rsp_idling = 1'b1;
   endtask

   initial begin
      foreach (text_window[i]) text_window[i] = '0;
      foreach (pat_words[i]) pat_words[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_default_pattern();
      test_special_patterns();
      test_random_lines();
      test_output_backpressure();
      test_no_idling();
      drain_block();
      if (fail_count == 0) begin
         $display("caseless_line_substring_filter_unit_test passed");
      end else begin
         $display("caseless_line_substring_filter_unit_test failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/clsf_pkg.sv
hw/rtl/clsf_front.sv
hw/rtl/clsf_queue.sv
hw/rtl/clsf_back.sv
hw/rtl/caseless_line_substring_filter_unit.sv
hw/rtl/clsf_checker.sv
test/caseless_line_substring_filter_unit_test.sv
